// ----- design/clipped_product_int8_dot_top_assert.svh -----
// Assertion macros shared by the block's checking code.
`ifndef CLIPPED_PRODUCT_INT8_DOT_TOP_ASSERT_SVH
`define CLIPPED_PRODUCT_INT8_DOT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CPD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cpd_pkg.sv -----
package cpd_pkg;

	localparam int ACC_W    = 16;
	localparam int WEIGHT_W = 8;
	localparam int CLIP_W   = 8;
	localparam int ROUND_W  = 16;
	localparam int SHIFT_W  = 5;
	localparam int ROUNDED_W = 17;  // 255*255 + 65535 fits 17 bits
	localparam int ACT_W    = 8;
	localparam int PROD_W   = ACT_W + 1 + WEIGHT_W;  // signed act x weight
	localparam int PAIR_W   = PROD_W + 1;
	localparam int SAT_W    = 16;
	localparam int SUM_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_ADD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 2'd2;

	localparam logic [CLIP_W-1:0]  CLIP_MAX_RST     = 8'd255;
	localparam logic [ROUND_W-1:0] ROUND_ADD_RST    = 16'd256;
	localparam logic [SHIFT_W-1:0] SHIFT_AMOUNT_RST = 5'd9;

	localparam logic signed [PAIR_W-1:0] PAIR_MAX = 18'sd32767;
	localparam logic signed [PAIR_W-1:0] PAIR_MIN = -18'sd32768;

	typedef struct packed {
		logic [CLIP_W-1:0]  clip_max;
		logic [ROUND_W-1:0] round_add;
		logic [SHIFT_W-1:0] shift_amount;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic last;
	} pipe_ctrl_t;

endpackage

// ----- design/cpd_if.sv -----
interface cpd_pair_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [cpd_pkg::ACC_W-1:0]        first_low;
	logic signed [cpd_pkg::ACC_W-1:0]        first_high;
	logic signed [cpd_pkg::ACC_W-1:0]        second_low;
	logic signed [cpd_pkg::ACC_W-1:0]        second_high;
	logic signed [cpd_pkg::WEIGHT_W-1:0]     first_weight;
	logic signed [cpd_pkg::WEIGHT_W-1:0]     second_weight;
	logic                                    last_pair;

	modport source (output valid, first_low, first_high, second_low, second_high,
		first_weight, second_weight, last_pair, input ready);
	modport sink (input valid, first_low, first_high, second_low, second_high,
		first_weight, second_weight, last_pair, output ready);
endinterface

interface cpd_sum_if;
	logic                              valid;
	logic                              ready;
	logic signed [cpd_pkg::SUM_W-1:0]  dot_sum;

	modport source (output valid, dot_sum, input ready);
	modport sink (input valid, dot_sum, output ready);
endinterface

// ----- design/cpd_lane.sv -----
// One element: clamp, product, rounding (s1); shift, truncate, weight (s2).
module cpd_lane (
	input  logic                                  clk,
	input  logic                                  en,
	input  cpd_pkg::cfg_t                         cfg,
	input  logic signed [cpd_pkg::ACC_W-1:0]      low,
	input  logic signed [cpd_pkg::ACC_W-1:0]      high,
	input  logic signed [cpd_pkg::WEIGHT_W-1:0]   weight,
	output logic signed [cpd_pkg::PROD_W-1:0]     prod_s2
);

	logic [cpd_pkg::CLIP_W-1:0]        low_c, high_c;
	logic [cpd_pkg::ROUNDED_W-1:0]     rounded;
	logic [cpd_pkg::ROUNDED_W-1:0]     rounded_s1;
	logic signed [cpd_pkg::WEIGHT_W-1:0] weight_s1;
	logic [cpd_pkg::ACT_W-1:0]         act;

	function automatic logic [cpd_pkg::CLIP_W-1:0] clamp(
		input logic signed [cpd_pkg::ACC_W-1:0] x,
		input logic [cpd_pkg::CLIP_W-1:0]       clip
	);
		logic [cpd_pkg::CLIP_W-1:0] r;
		if (x[cpd_pkg::ACC_W-1]) begin
			r = '0;
		end else if ($unsigned(x) > {{(cpd_pkg::ACC_W-cpd_pkg::CLIP_W){1'b0}}, clip}) begin
			r = clip;
		end else begin
			r = x[cpd_pkg::CLIP_W-1:0];
		end
		return r;
	endfunction

	assign low_c   = clamp(low, cfg.clip_max);
	assign high_c  = clamp(high, cfg.clip_max);
	assign rounded = cpd_pkg::ROUNDED_W'(low_c) * cpd_pkg::ROUNDED_W'(high_c)
		+ cpd_pkg::ROUNDED_W'(cfg.round_add);

	// shifts of 17 and up simply empty the word
	assign act = cpd_pkg::ACT_W'(rounded_s1 >> cfg.shift_amount);

	always_ff @(posedge clk) begin
		if (en) begin
			rounded_s1 <= rounded;
			weight_s1  <= weight;
			prod_s2    <= $signed({1'b0, act}) * weight_s1;
		end
	end

endmodule

// ----- design/cpd_merge.sv -----
// Pair sum, saturation, running accumulation and result register.
module cpd_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  cpd_pkg::pipe_ctrl_t                  ctrl_s2,
	input  logic signed [cpd_pkg::PROD_W-1:0]    prod0_s2,
	input  logic signed [cpd_pkg::PROD_W-1:0]    prod1_s2,
	cpd_sum_if.source                            sums
);

	logic signed [cpd_pkg::PAIR_W-1:0] pair;
	logic signed [cpd_pkg::SAT_W-1:0]  pair_sat;
	logic [cpd_pkg::SUM_W-1:0]         sum_next;
	logic [cpd_pkg::SUM_W-1:0]         running_q;
	logic [cpd_pkg::SUM_W-1:0]         dot_q;
	logic                              valid_q;
	logic                              take;

	assign pair = cpd_pkg::PAIR_W'(prod0_s2) + cpd_pkg::PAIR_W'(prod1_s2);

	always_comb begin
		priority if (pair > cpd_pkg::PAIR_MAX) begin
			pair_sat = cpd_pkg::SAT_W'(cpd_pkg::PAIR_MAX);
		end else if (pair < cpd_pkg::PAIR_MIN) begin
			pair_sat = cpd_pkg::SAT_W'(cpd_pkg::PAIR_MIN);
		end else begin
			pair_sat = pair[cpd_pkg::SAT_W-1:0];
		end
	end

	assign sum_next = running_q + cpd_pkg::SUM_W'(pair_sat);
	assign take     = en && ctrl_s2.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (take) begin
				running_q <= ctrl_s2.last ? '0 : sum_next;
			end
			if (take && ctrl_s2.last) begin
				valid_q <= 1'b1;
			end else if (sums.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctrl_s2.last) begin
			dot_q <= sum_next;
		end
	end

	assign sums.valid   = valid_q;
	assign sums.dot_sum = $signed(dot_q);

endmodule

// ----- design/clipped_product_int8_dot_top.sv -----
// Channel  Dir  Payload                                         Transfer
// pairs    in   first/second low,high (s16), weights (s8), last valid & ready
// sums     out  dot_sum (s32)                                   valid & ready
// cfg      in   cfg_index (2b), cfg_data (16b)                  cfg_we
//
// One pair per cycle unless the pipe stalls; each element has its own lane (clamp/multiply, then
// shift/weight multiply), merged in a third stage into the running sum.
// A last pair's dot_sum goes valid once the merge has registered its result.
// arst_n clears pipeline valids, running sum and result valid; config to defaults.
// The pipe stalls only when a last pair reaches the merge while the previous
// result has not been taken.
`include "clipped_product_int8_dot_top_assert.svh"

module clipped_product_int8_dot_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cpd_pkg::CFG_DATA_W-1:0]      cfg_data,
	cpd_pair_if.sink                            pairs,
	cpd_sum_if.source                           sums
);

	cpd_pkg::cfg_t       cfg_q;
	cpd_pkg::pipe_ctrl_t ctrl_s1, ctrl_s2;
	logic                adv;
	logic                accept;
	logic signed [cpd_pkg::PROD_W-1:0] prod0_s2, prod1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_max     <= cpd_pkg::CLIP_MAX_RST;
			cfg_q.round_add    <= cpd_pkg::ROUND_ADD_RST;
			cfg_q.shift_amount <= cpd_pkg::SHIFT_AMOUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpd_pkg::REG_CLIP_MAX: begin
					cfg_q.clip_max <= cfg_data[cpd_pkg::CLIP_W-1:0];
				end
				cpd_pkg::REG_ROUND_ADD: begin
					cfg_q.round_add <= cfg_data[cpd_pkg::ROUND_W-1:0];
				end
				cpd_pkg::REG_SHIFT_AMOUNT: begin
					cfg_q.shift_amount <= cfg_data[cpd_pkg::SHIFT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// hold only if a result must land in an occupied output register
	assign adv    = !(ctrl_s2.valid && ctrl_s2.last && sums.valid && !sums.ready);
	assign accept = pairs.valid && adv;
	assign pairs.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s1.valid <= pairs.valid;
			ctrl_s1.last  <= pairs.last_pair;
			ctrl_s2       <= ctrl_s1;
		end
	end

	cpd_lane u_lane0 (
		.clk     (clk),
		.en      (adv),
		.cfg     (cfg_q),
		.low     (pairs.first_low),
		.high    (pairs.first_high),
		.weight  (pairs.first_weight),
		.prod_s2 (prod0_s2)
	);

	cpd_lane u_lane1 (
		.clk     (clk),
		.en      (adv),
		.cfg     (cfg_q),
		.low     (pairs.second_low),
		.high    (pairs.second_high),
		.weight  (pairs.second_weight),
		.prod_s2 (prod1_s2)
	);

	cpd_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctrl_s2  (ctrl_s2),
		.prod0_s2 (prod0_s2),
		.prod1_s2 (prod1_s2),
		.sums     (sums)
	);

	`CPD_ASSERT_NEXT(a_accept_fills_s1, accept, ctrl_s1.valid,
		"transferred pair missing from stage 1")
	`CPD_ASSERT_NEXT(a_last_gives_result, ctrl_s2.valid && ctrl_s2.last && adv, sums.valid,
		"last pair left the merge without a result")
	`CPD_ASSERT_IMP(a_result_has_source, $rose(sums.valid),
		$past(ctrl_s2.valid && ctrl_s2.last && adv), "result appeared without a last pair")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int PIPE_LAT      = 3;
	localparam int SETTLE_CYCLES = PIPE_LAT + 5;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int BLOCK_PAIRS   = 150;
	localparam logic [cpd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic signed [cpd_pkg::ACC_W-1:0]    first_low;
		logic signed [cpd_pkg::ACC_W-1:0]    first_high;
		logic signed [cpd_pkg::ACC_W-1:0]    second_low;
		logic signed [cpd_pkg::ACC_W-1:0]    second_high;
		logic signed [cpd_pkg::WEIGHT_W-1:0] first_weight;
		logic signed [cpd_pkg::WEIGHT_W-1:0] second_weight;
		logic                                last_pair;
	} pair_t;

	typedef enum {ROW_PAIR, ROW_REGS} row_kind_t;

	typedef struct {
		row_kind_t                        kind;
		pair_t                            pair;
		bit                               typed;
		logic signed [cpd_pkg::SUM_W-1:0] typed_sum;
		cpd_pkg::cfg_t                    regs;
		bit                               poke_spare;
	} row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data;

	cpd_pair_if pairs();
	cpd_sum_if  sums();

	clipped_product_int8_dot_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pairs     (pairs),
		.sums      (sums)
	);

	cpd_pkg::cfg_t                    active_regs;
	int                               acc_sum;
	logic signed [cpd_pkg::SUM_W-1:0] sum_expect_q[$];
	row_t                             directed_rows[$];
	int                               src_idle_pct;
	int                               sink_stall_pct;
	int                               n_errors;
	int                               n_pairs;
	int                               n_sums;
	int                               n_settings;
	int                               cycle_cnt;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [cpd_pkg::CLIP_W-1:0] clamp_acc(
			logic signed [cpd_pkg::ACC_W-1:0] x);
		if (x < 0)
			return '0;
		if (int'(x) > int'(active_regs.clip_max))
			return active_regs.clip_max;
		return x[cpd_pkg::CLIP_W-1:0];
	endfunction

	function automatic logic [cpd_pkg::ACT_W-1:0] activation_of(
			logic signed [cpd_pkg::ACC_W-1:0] lo, logic signed [cpd_pkg::ACC_W-1:0] hi);
		logic [cpd_pkg::ROUNDED_W-1:0] rounded;
		rounded = cpd_pkg::ROUNDED_W'(clamp_acc(lo)) * cpd_pkg::ROUNDED_W'(clamp_acc(hi))
			+ cpd_pkg::ROUNDED_W'(active_regs.round_add);
		// shifts past the rounded width simply give zero
		return cpd_pkg::ACT_W'(rounded >> active_regs.shift_amount);
	endfunction

	function automatic int pair_contribution(pair_t p);
		int prod;
		prod = int'(activation_of(p.first_low, p.first_high)) * int'(p.first_weight)
			+ int'(activation_of(p.second_low, p.second_high)) * int'(p.second_weight);
		if (prod > cpd_pkg::PAIR_MAX)
			prod = cpd_pkg::PAIR_MAX;
		else if (prod < cpd_pkg::PAIR_MIN)
			prod = cpd_pkg::PAIR_MIN;
		return prod;
	endfunction

	function automatic void note_transfer(pair_t p, bit typed,
			logic signed [cpd_pkg::SUM_W-1:0] typed_sum);
		acc_sum += pair_contribution(p);
		n_pairs++;
		if (p.last_pair) begin
			sum_expect_q.push_back(typed ? typed_sum : cpd_pkg::SUM_W'(acc_sum));
			acc_sum = 0;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic logic signed [cpd_pkg::ACC_W-1:0] rand_acc();
		case ($urandom_range(4))
			0: return cpd_pkg::ACC_W'($urandom);
			1: return cpd_pkg::ACC_W'($urandom_range(int'(active_regs.clip_max) + 2, 0));
			2: return cpd_pkg::ACC_W'(-int'($urandom_range(300, 1)));
			3: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return cpd_pkg::ACC_W'($urandom_range(int'(active_regs.clip_max),
				int'(active_regs.clip_max) / 2));
		endcase
	endfunction

	function automatic pair_t rand_pair(bit last);
		pair_t p;
		p.first_low     = rand_acc();
		p.first_high    = rand_acc();
		p.second_low    = rand_acc();
		p.second_high   = rand_acc();
		p.first_weight  = cpd_pkg::WEIGHT_W'($urandom);
		p.second_weight = cpd_pkg::WEIGHT_W'($urandom);
		p.last_pair     = last;
		// odd tail: second element carries a zero weight
		if (last && $urandom_range(3) == 0)
			p.second_weight = '0;
		return p;
	endfunction

	function automatic cpd_pkg::cfg_t rand_regs();
		cpd_pkg::cfg_t r;
		case ($urandom_range(3))
			0: r.clip_max = '0;
			1: r.clip_max = '1;
			default: r.clip_max = cpd_pkg::CLIP_W'($urandom);
		endcase
		case ($urandom_range(3))
			0: r.round_add = '0;
			1: r.round_add = '1;
			default: r.round_add = cpd_pkg::ROUND_W'($urandom);
		endcase
		case ($urandom_range(5))
			0: r.shift_amount = cpd_pkg::SHIFT_W'($urandom_range(31, 17));
			1: r.shift_amount = 5'd16;
			2: r.shift_amount = 5'd0;
			default: r.shift_amount = cpd_pkg::SHIFT_W'($urandom_range(12, 1));
		endcase
		return r;
	endfunction

	function automatic void add_pair(int fl, int fh, int sl, int sh, int fw, int sw, bit last,
			bit typed = 1'b0, int typed_sum = 0);
		row_t r;
		r.kind               = ROW_PAIR;
		r.pair.first_low     = cpd_pkg::ACC_W'(fl);
		r.pair.first_high    = cpd_pkg::ACC_W'(fh);
		r.pair.second_low    = cpd_pkg::ACC_W'(sl);
		r.pair.second_high   = cpd_pkg::ACC_W'(sh);
		r.pair.first_weight  = cpd_pkg::WEIGHT_W'(fw);
		r.pair.second_weight = cpd_pkg::WEIGHT_W'(sw);
		r.pair.last_pair     = last;
		r.typed              = typed;
		r.typed_sum          = cpd_pkg::SUM_W'(typed_sum);
		r.poke_spare         = 1'b0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_regs(int clip, int rnd, int sh, bit spare = 1'b0);
		row_t r;
		r.kind                = ROW_REGS;
		r.typed               = 1'b0;
		r.regs.clip_max       = cpd_pkg::CLIP_W'(clip);
		r.regs.round_add      = cpd_pkg::ROUND_W'(rnd);
		r.regs.shift_amount   = cpd_pkg::SHIFT_W'(sh);
		r.poke_spare          = spare;
		directed_rows.push_back(r);
	endfunction

	task automatic send_pair(pair_t p, bit typed = 1'b0,
			logic signed [cpd_pkg::SUM_W-1:0] typed_sum = '0);
		while ($urandom_range(99) < src_idle_pct) begin
			pairs.valid <= 1'b0;
			@(posedge clk);
		end
		pairs.valid         <= 1'b1;
		pairs.first_low     <= p.first_low;
		pairs.first_high    <= p.first_high;
		pairs.second_low    <= p.second_low;
		pairs.second_high   <= p.second_high;
		pairs.first_weight  <= p.first_weight;
		pairs.second_weight <= p.second_weight;
		pairs.last_pair     <= p.last_pair;
		@(posedge clk);
		while (!pairs.ready)
			@(posedge clk);
		note_transfer(p, typed, typed_sum);
	endtask

	// non-last pairs give no result, so let the pipe empty past its latency too
	task automatic drain_pipe();
		pairs.valid <= 1'b0;
		@(posedge clk);
		while (sum_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(cpd_pkg::cfg_t r, bit poke_spare);
		// upper data bits are junk on the narrow registers
		cfg_we    <= 1'b1;
		cfg_index <= cpd_pkg::REG_CLIP_MAX;
		cfg_data  <= {8'($urandom), r.clip_max};
		@(posedge clk);
		cfg_index <= cpd_pkg::REG_ROUND_ADD;
		cfg_data  <= r.round_add;
		@(posedge clk);
		cfg_index <= cpd_pkg::REG_SHIFT_AMOUNT;
		cfg_data  <= {11'($urandom), r.shift_amount};
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data  <= 16'($urandom);
			@(posedge clk);
		end
		cfg_we      <= 1'b0;
		active_regs = r;
		n_settings++;
	endtask

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin : sum_check
		logic signed [cpd_pkg::SUM_W-1:0] want;
		if (arst_n && sums.valid && sums.ready) begin
			n_sums++;
			if (sum_expect_q.size() == 0) begin
				n_errors++;
				$display("%0t: dot_sum transfer with nothing expected, got %0d",
					$time, sums.dot_sum);
			end else begin
				want = sum_expect_q.pop_front();
				if (sums.dot_sum !== want) begin
					n_errors++;
					$display("%0t: dot_sum mismatch, expected %0d, got %0d",
						$time, want, sums.dot_sum);
				end
			end
		end
	end

	always @(posedge clk)
		sums.ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
			$display("testbench: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : main_seq
		int   src_pct[3];
		int   sink_pct[3];
		int   sent;
		int   vec_len;
		bit   paused;

		src_pct  = '{13, 63, 0};
		sink_pct = '{63, 13, 0};

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= cpd_pkg::REG_CLIP_MAX;
		cfg_data            <= '0;
		pairs.valid         <= 1'b0;
		pairs.first_low     <= '0;
		pairs.first_high    <= '0;
		pairs.second_low    <= '0;
		pairs.second_high   <= '0;
		pairs.first_weight  <= '0;
		pairs.second_weight <= '0;
		pairs.last_pair     <= 1'b0;

		active_regs.clip_max     = cpd_pkg::CLIP_MAX_RST;
		active_regs.round_add    = cpd_pkg::ROUND_ADD_RST;
		active_regs.shift_amount = cpd_pkg::SHIFT_AMOUNT_RST;
		acc_sum        = 0;
		src_idle_pct   = src_pct[0];
		sink_stall_pct = sink_pct[0];

		// reset defaults: clip 255, round 256, shift 9 -> full-scale activation 127
		add_pair(0, 0, 0, 0, 127, -128, 1, 1, 0);
		add_pair(32767, 32767, 32767, 32767, 127, 127, 1, 1, 32258);
		add_pair(32767, 32767, 32767, 32767, -128, -128, 1, 1, -32512);
		add_pair(-32768, -32768, -32768, -32768, 127, -128, 1, 1, 0);
		add_pair(32767, 32767, 32767, 32767, -128, 0, 1, 1, -16256);
		add_pair(100, 200, 255, 1, 55, -7, 0);
		add_pair(256, 300, -1, 40, -128, 127, 0);
		add_pair(3, 7, 128, 128, 1, -1, 1);
		// no rounding, no shift: saturation and 8-bit truncation
		add_regs(255, 0, 0);
		add_pair(15, 15, 15, 15, 127, 127, 1, 1, 32767);
		add_pair(15, 15, 15, 15, -128, -128, 1, 1, -32768);
		add_pair(16, 16, 0, 0, 127, 0, 1, 1, 0);
		add_pair(255, 255, 0, 0, -128, 0, 1, 1, -128);
		// zero clip: activation is the shifted rounding constant
		add_regs(0, 65535, 8);
		add_pair(1234, -5, 32767, 0, 127, 127, 1, 1, 32767);
		add_pair(-32768, 32767, 7, 7, -1, 1, 1);
		add_regs(255, 65535, 16);
		add_pair(32767, 32767, 0, 0, 100, 100, 1, 1, 100);
		// shift past the rounded width, plus a write to the unused index
		add_regs(255, 65535, 17, 1);
		add_pair(32767, 32767, 32767, 32767, 127, 127, 1, 1, 0);
		add_regs(128, 1234, 31);
		add_pair(200, -3, 64, 64, -128, 127, 1);
		add_regs(255, 256, 9);
		add_pair(20, 30, 500, -700, 90, -90, 0);
		add_pair(32767, 1, 2, 32767, -128, 127, 1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REGS) begin
				drain_pipe();
				program_regs(directed_rows[i].regs, directed_rows[i].poke_spare);
			end else begin
				send_pair(directed_rows[i].pair, directed_rows[i].typed,
					directed_rows[i].typed_sum);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct   = src_pct[phase];
			sink_stall_pct = sink_pct[phase];
			for (int blk = 0; blk < 3; blk++) begin
				drain_pipe();
				program_regs(rand_regs(), $urandom_range(3) == 0);
				sent   = 0;
				paused = 1'b0;
				while (sent < BLOCK_PAIRS) begin
					vec_len = ($urandom_range(9) == 0) ? $urandom_range(40, 1)
						: $urandom_range(6, 1);
					for (int k = 1; k <= vec_len; k++) begin
						send_pair(rand_pair(k == vec_len));
						sent++;
					end
					// hold the sender off until every sum is back
					if (blk == 1 && !paused && sent >= BLOCK_PAIRS / 2) begin
						drain_pipe();
						paused = 1'b1;
					end
				end
			end
		end

		drain_pipe();
		$display("pairs transferred: %0d over %0d register settings", n_pairs, n_settings);
		$display("sums compared: %0d, mismatches: %0d", n_sums, n_errors);
		if (n_errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/cpd_pkg.sv
design/cpd_if.sv
design/cpd_lane.sv
design/cpd_merge.sv
design/clipped_product_int8_dot_top.sv
verif/testbench.sv
